// File: src/tun_pkg.sv
package tun_pkg;

    // Field widths of the ports.
    localparam int COORD_W = 32;
    localparam int OUT_W = 16;

    // Internal arithmetic widths.
    localparam int EDGE_W = COORD_W + 1;
    localparam int HALF_W = 16;
    localparam int PART_W = 2 * (EDGE_W - HALF_W);
    localparam int PROD_W = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W = PROD_W;
    localparam int NORM_W = 31;
    localparam int SQ_W = 2 * NORM_W;
    localparam int SUM_W = 64;
    localparam int ROOT_W = SUM_W / 2;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int REM_W = ROOT_W + 2;
    localparam int FRAC_BITS = 14;
    localparam int QUOT_W = FRAC_BITS + 1;
    localparam int NUM_W = NORM_W + FRAC_BITS + 1;

    // Leading-one search and normalizing shift.
    localparam int GRP_W = 16;
    localparam int GRP_N = (MAG_W + GRP_W - 1) / GRP_W;
    localparam int GRP_IDX_W = $clog2(GRP_N);
    localparam int POS_W = $clog2(GRP_W);
    localparam int SHIFT_W = GRP_IDX_W + POS_W;
    localparam int TOP_POS = MAG_W - 1;
    localparam int M_LSB = MAG_W - NORM_W;

    // Pipeline depths.
    localparam int FRONT_STAGES = 9;
    localparam int BACK_STAGES = 2 + ROOT_STEPS + 1 + QUOT_W + 1;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic                  deg;
        logic [2:0]            neg;
        logic [NORM_W-1:0]     mx;
        logic [NORM_W-1:0]     my;
        logic [NORM_W-1:0]     mz;
    } tun_item_t;

    // Sign and degenerate flags that travel along the back pipeline.
    typedef struct packed {
        logic       deg;
        logic [2:0] neg;
    } tun_meta_t;

endpackage

// File: src/tun_if.sv
interface tun_in_if;
    import tun_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  ax;
    logic signed [COORD_W-1:0]  ay;
    logic signed [COORD_W-1:0]  az;
    logic signed [COORD_W-1:0]  bx;
    logic signed [COORD_W-1:0]  by;
    logic signed [COORD_W-1:0]  bz;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [COORD_W-1:0]  cz;

    modport source (
        output valid, ax, ay, az, bx, by, bz, cx, cy, cz,
        input  ready
    );

    modport sink (
        input  valid, ax, ay, az, bx, by, bz, cx, cy, cz,
        output ready
    );
endinterface

interface tun_out_if;
    import tun_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  normal_x;
    logic signed [OUT_W-1:0]  normal_y;
    logic signed [OUT_W-1:0]  normal_z;
    logic                     degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );

    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

// File: src/tun_front.sv
module tun_front (
    input  logic              clk,
    input  logic              rst_n,
    tun_in_if.sink            tri_in,
    output logic              item_valid,
    input  logic              item_ready,
    output tun_pkg::tun_item_t item
);
    import tun_pkg::*;

    // Position of the highest set bit in one group.
    function automatic logic [POS_W-1:0] lead_pos(input logic [GRP_W-1:0] x);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < GRP_W; i++)
        begin
            if (x[i])
            begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

    logic                          en;
    logic [FRONT_STAGES-1:0]       vld_reg;

    logic signed [EDGE_W-1:0]      u_reg [3];
    logic signed [EDGE_W-1:0]      v_reg [3];
    logic signed [EDGE_W-1:0]      op_a [6];
    logic signed [EDGE_W-1:0]      op_b [6];
    logic signed [PART_W-1:0]      pp_hh_reg [6];
    logic signed [PART_W-1:0]      pp_hl_reg [6];
    logic signed [PART_W-1:0]      pp_lh_reg [6];
    logic signed [PART_W-1:0]      pp_ll_reg [6];
    logic signed [PROD_W-1:0]      prod_reg [6];
    logic signed [CROSS_W-1:0]     cross_reg [3];
    logic [MAG_W-1:0]              mag5_reg [3];
    logic [2:0]                    neg5_reg;
    logic [MAG_W-1:0]              or_reg;
    logic [MAG_W-1:0]              mag6_reg [3];
    logic [2:0]                    neg6_reg;
    logic                          deg6_reg;
    logic [GRP_N-1:0]              nz_reg;
    logic [POS_W-1:0]              pos_reg [GRP_N];
    logic [MAG_W-1:0]              mag7_reg [3];
    logic [2:0]                    neg7_reg;
    logic                          deg7_reg;
    logic [SHIFT_W-1:0]            shift7_reg;
    logic [MAG_W-1:0]              mag8_reg [3];
    logic [2:0]                    neg8_reg;
    logic                          deg8_reg;
    logic [SHIFT_W-1:0]            shift8_reg;
    tun_item_t                     item_reg;
    logic [GRP_N*GRP_W-1:0]        padded;
    logic [SHIFT_W-1:0]            top_pos;

    // The whole front advances unless its last stage is blocked.
    assign en = !vld_reg[FRONT_STAGES-1] || item_ready;
    assign tri_in.ready = en;
    assign item_valid = vld_reg[FRONT_STAGES-1];
    assign item = item_reg;

    // Valid bits shift along with the payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], tri_in.valid};
        end
    end

    // Edge vectors relative to the third vertex, exact at 33 bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0] <= EDGE_W'(tri_in.ax) - EDGE_W'(tri_in.cx);
            u_reg[1] <= EDGE_W'(tri_in.ay) - EDGE_W'(tri_in.cy);
            u_reg[2] <= EDGE_W'(tri_in.az) - EDGE_W'(tri_in.cz);
            v_reg[0] <= EDGE_W'(tri_in.bx) - EDGE_W'(tri_in.cx);
            v_reg[1] <= EDGE_W'(tri_in.by) - EDGE_W'(tri_in.cy);
            v_reg[2] <= EDGE_W'(tri_in.bz) - EDGE_W'(tri_in.cz);
        end
    end

    // Operand pairs of the six cross product terms.
    always_comb
    begin
        op_a[0] = u_reg[1]; op_b[0] = v_reg[2];
        op_a[1] = u_reg[2]; op_b[1] = v_reg[1];
        op_a[2] = u_reg[2]; op_b[2] = v_reg[0];
        op_a[3] = u_reg[0]; op_b[3] = v_reg[2];
        op_a[4] = u_reg[0]; op_b[4] = v_reg[1];
        op_a[5] = u_reg[1]; op_b[5] = v_reg[0];
    end

    // Each 33x33 product is split into four 17x17 partial products.
    for (genvar k = 0; k < 6; k++)
    begin : g_part
        logic signed [EDGE_W-HALF_W-1:0] a_hi;
        logic signed [EDGE_W-HALF_W-1:0] a_lo;
        logic signed [EDGE_W-HALF_W-1:0] b_hi;
        logic signed [EDGE_W-HALF_W-1:0] b_lo;

        assign a_hi = op_a[k][EDGE_W-1:HALF_W];
        assign a_lo = {1'b0, op_a[k][HALF_W-1:0]};
        assign b_hi = op_b[k][EDGE_W-1:HALF_W];
        assign b_lo = {1'b0, op_b[k][HALF_W-1:0]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pp_hh_reg[k] <= a_hi * b_hi;
                pp_hl_reg[k] <= a_hi * b_lo;
                pp_lh_reg[k] <= a_lo * b_hi;
                pp_ll_reg[k] <= a_lo * b_lo;
            end
        end

        // Partial products are recombined into the full product.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[k] <= (PROD_W'(pp_hh_reg[k]) <<< (2 * HALF_W))
                             + ((PROD_W'(pp_hl_reg[k]) + PROD_W'(pp_lh_reg[k])) <<< HALF_W)
                             + PROD_W'(pp_ll_reg[k]);
            end
        end
    end

    // Cross product components.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cross_reg[0] <= CROSS_W'(prod_reg[0]) - CROSS_W'(prod_reg[1]);
            cross_reg[1] <= CROSS_W'(prod_reg[2]) - CROSS_W'(prod_reg[3]);
            cross_reg[2] <= CROSS_W'(prod_reg[4]) - CROSS_W'(prod_reg[5]);
        end
    end

    // Sign and magnitude split; the OR of the magnitudes has the top bit of the largest.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg5_reg[i] <= cross_reg[i][CROSS_W-1];
                mag5_reg[i] <= cross_reg[i][CROSS_W-1] ? MAG_W'(-cross_reg[i])
                                                      : MAG_W'(cross_reg[i]);
            end
            or_reg <= MAG_W'(cross_reg[0][CROSS_W-1] ? -cross_reg[0] : cross_reg[0])
                    | MAG_W'(cross_reg[1][CROSS_W-1] ? -cross_reg[1] : cross_reg[1])
                    | MAG_W'(cross_reg[2][CROSS_W-1] ? -cross_reg[2] : cross_reg[2]);
        end
    end

    // Leading-one search, first within each 16-bit group.
    assign padded = (GRP_N*GRP_W)'(or_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < GRP_N; g++)
            begin
                nz_reg[g] <= |padded[g*GRP_W +: GRP_W];
                pos_reg[g] <= lead_pos(padded[g*GRP_W +: GRP_W]);
            end
            mag6_reg <= mag5_reg;
            neg6_reg <= neg5_reg;
            deg6_reg <= (or_reg == '0);
        end
    end

    // Then across the groups, giving the left shift that puts the top bit at the MSB.
    always_comb
    begin
        top_pos = '0;
        for (int g = 0; g < GRP_N; g++)
        begin
            if (nz_reg[g])
            begin
                top_pos = {GRP_IDX_W'(g), pos_reg[g]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shift7_reg <= SHIFT_W'(TOP_POS) - top_pos;
            mag7_reg <= mag6_reg;
            neg7_reg <= neg6_reg;
            deg7_reg <= deg6_reg;
        end
    end

    // Coarse shift by whole bytes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag8_reg[i] <= mag7_reg[i] << {shift7_reg[SHIFT_W-1:3], 3'b000};
            end
            shift8_reg <= shift7_reg;
            neg8_reg <= neg7_reg;
            deg8_reg <= deg7_reg;
        end
    end

    // Fine shift; the upper 31 bits are the normalized magnitudes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg.mx <= NORM_W'((mag8_reg[0] << shift8_reg[2:0]) >> M_LSB);
            item_reg.my <= NORM_W'((mag8_reg[1] << shift8_reg[2:0]) >> M_LSB);
            item_reg.mz <= NORM_W'((mag8_reg[2] << shift8_reg[2:0]) >> M_LSB);
            item_reg.neg <= neg8_reg;
            item_reg.deg <= deg8_reg;
        end
    end

endmodule

// File: src/tun_queue.sv
module tun_queue #(
    parameter int DEPTH = tun_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  tun_pkg::tun_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output tun_pkg::tun_item_t pop_item
);
    import tun_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tun_item_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_item = slot_reg[rd_ptr_reg];

    // Storage is written at the tail.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/tun_back.sv
module tun_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tun_pkg::tun_item_t item,
    tun_out_if.source          normal_out
);
    import tun_pkg::*;

    localparam int ROOT_BASE = 2;
    localparam int NUM_IDX = ROOT_BASE + ROOT_STEPS;
    localparam int DIV_BASE = NUM_IDX + 1;

    logic                          en;
    logic [BACK_STAGES-1:0]        vld_reg;

    logic [SQ_W-1:0]               sq_reg [3];
    tun_item_t                     sq_item_reg;
    logic [SUM_W-1:0]              sum_reg;
    tun_item_t                     sum_item_reg;

    logic [REM_W-1:0]              root_rem_reg [ROOT_STEPS];
    logic [ROOT_W-1:0]             root_val_reg [ROOT_STEPS];
    logic [SUM_W-1:0]              root_src_reg [ROOT_STEPS];
    tun_item_t                     root_item_reg [ROOT_STEPS];

    logic [2:0][NUM_W-1:0]         num_reg;
    logic [ROOT_W-1:0]             len_reg;
    tun_meta_t                     num_meta_reg;

    logic [2:0][ROOT_W-1:0]        div_rem_reg [QUOT_W];
    logic [2:0][QUOT_W-1:0]        div_quot_reg [QUOT_W];
    logic [2:0][NUM_W-1:0]         div_num_reg [QUOT_W];
    logic [ROOT_W-1:0]             div_len_reg [QUOT_W];
    tun_meta_t                     div_meta_reg [QUOT_W];

    logic signed [OUT_W-1:0]       out_x_reg;
    logic signed [OUT_W-1:0]       out_y_reg;
    logic signed [OUT_W-1:0]       out_z_reg;
    logic                          out_deg_reg;

    // The back pipeline advances unless its output register is held.
    assign en = !vld_reg[BACK_STAGES-1] || normal_out.ready;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[BACK_STAGES-2:0], item_valid};
        end
    end

    // Squares of the normalized magnitudes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= SQ_W'(item.mx) * SQ_W'(item.mx);
            sq_reg[1] <= SQ_W'(item.my) * SQ_W'(item.my);
            sq_reg[2] <= SQ_W'(item.mz) * SQ_W'(item.mz);
            sq_item_reg <= item;
        end
    end

    // Sum of squares, exact in 64 bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            sum_item_reg <= sq_item_reg;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_root
        logic [REM_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [SUM_W-1:0]   src_in;
        tun_item_t          item_in;
        logic [REM_W+1:0]   rem_sh;
        logic [REM_W+1:0]   trial;
        logic               take;

        if (j == 0)
        begin : g_first
            assign rem_in = '0;
            assign root_in = '0;
            assign src_in = sum_reg;
            assign item_in = sum_item_reg;
        end
        else
        begin : g_next
            assign rem_in = root_rem_reg[j-1];
            assign root_in = root_val_reg[j-1];
            assign src_in = root_src_reg[j-1];
            assign item_in = root_item_reg[j-1];
        end

        assign rem_sh = {rem_in, src_in[SUM_W-1-2*j -: 2]};
        assign trial = (REM_W+2)'({root_in, 2'b01});
        assign take = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_rem_reg[j] <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_val_reg[j] <= {root_in[ROOT_W-2:0], take};
                root_src_reg[j] <= src_in;
                root_item_reg[j] <= item_in;
            end
        end
    end

    // Rounded numerators: magnitude scaled to Q1.14 plus half the length.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= {root_item_reg[ROOT_STEPS-1].mx, FRAC_BITS'(0)}
                        + NUM_W'(root_val_reg[ROOT_STEPS-1] >> 1);
            num_reg[1] <= {root_item_reg[ROOT_STEPS-1].my, FRAC_BITS'(0)}
                        + NUM_W'(root_val_reg[ROOT_STEPS-1] >> 1);
            num_reg[2] <= {root_item_reg[ROOT_STEPS-1].mz, FRAC_BITS'(0)}
                        + NUM_W'(root_val_reg[ROOT_STEPS-1] >> 1);
            len_reg <= root_val_reg[ROOT_STEPS-1];
            num_meta_reg.deg <= root_item_reg[ROOT_STEPS-1].deg;
            num_meta_reg.neg <= root_item_reg[ROOT_STEPS-1].neg;
        end
    end

    // Restoring division, one quotient bit per stage for all three components.
    for (genvar b = 0; b < QUOT_W; b++)
    begin : g_div
        logic [2:0][ROOT_W-1:0]  rem_in;
        logic [2:0][QUOT_W-1:0]  quot_in;
        logic [2:0][NUM_W-1:0]   num_in;
        logic [ROOT_W-1:0]       len_in;
        tun_meta_t               meta_in;
        logic [2:0][ROOT_W:0]    rem_sh;
        logic [2:0]              take;

        if (b == 0)
        begin : g_first
            assign rem_in[0] = ROOT_W'(num_reg[0][NUM_W-1:QUOT_W]);
            assign rem_in[1] = ROOT_W'(num_reg[1][NUM_W-1:QUOT_W]);
            assign rem_in[2] = ROOT_W'(num_reg[2][NUM_W-1:QUOT_W]);
            assign quot_in = '0;
            assign num_in = num_reg;
            assign len_in = len_reg;
            assign meta_in = num_meta_reg;
        end
        else
        begin : g_next
            assign rem_in = div_rem_reg[b-1];
            assign quot_in = div_quot_reg[b-1];
            assign num_in = div_num_reg[b-1];
            assign len_in = div_len_reg[b-1];
            assign meta_in = div_meta_reg[b-1];
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                rem_sh[c] = {rem_in[c], num_in[c][QUOT_W-1-b]};
                take[c] = (rem_sh[c] >= {1'b0, len_in});
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    div_rem_reg[b][c] <= take[c] ? ROOT_W'(rem_sh[c] - {1'b0, len_in})
                                                 : ROOT_W'(rem_sh[c]);
                    div_quot_reg[b][c] <= {quot_in[c][QUOT_W-2:0], take[c]};
                end
                div_num_reg[b] <= num_in;
                div_len_reg[b] <= len_in;
                div_meta_reg[b] <= meta_in;
            end
        end
    end

    // Sign is applied last; a degenerate triangle gives the zero vector.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_deg_reg <= div_meta_reg[QUOT_W-1].deg;
            if (div_meta_reg[QUOT_W-1].deg)
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_z_reg <= '0;
            end
            else
            begin
                out_x_reg <= div_meta_reg[QUOT_W-1].neg[0]
                           ? -OUT_W'(div_quot_reg[QUOT_W-1][0])
                           : OUT_W'(div_quot_reg[QUOT_W-1][0]);
                out_y_reg <= div_meta_reg[QUOT_W-1].neg[1]
                           ? -OUT_W'(div_quot_reg[QUOT_W-1][1])
                           : OUT_W'(div_quot_reg[QUOT_W-1][1]);
                out_z_reg <= div_meta_reg[QUOT_W-1].neg[2]
                           ? -OUT_W'(div_quot_reg[QUOT_W-1][2])
                           : OUT_W'(div_quot_reg[QUOT_W-1][2]);
            end
        end
    end

    assign normal_out.valid = vld_reg[BACK_STAGES-1];
    assign normal_out.normal_x = out_x_reg;
    assign normal_out.normal_y = out_y_reg;
    assign normal_out.normal_z = out_z_reg;
    assign normal_out.degenerate = out_deg_reg;

endmodule

// File: src/triangle_unit_normal.sv
// Channel      Direction  Payload
// tri_in       in         ax, ay, az, bx, by, bz, cx, cy, cz (signed Q16.16)
// normal_out   out        normal_x, normal_y, normal_z (signed Q1.14), degenerate
//
// One triangle is taken every cycle while tri_in.ready is high; there is no per-item iteration.
// The front computes the edges, cross product, leading-one search and normalizing
// shift; items pass through the queue into the back, which computes the squares,
// sum, 32 square root steps, numerators, 15 divide steps and the output.
// Reset clears only valid bits, queue pointers and the queue count; no data register is reset.
// A stalled output holds the back; the queue lets the front keep taking items until it fills.
module triangle_unit_normal #(
    parameter int QUEUE_DEPTH = tun_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    tun_in_if.sink      tri_in,
    tun_out_if.source   normal_out
);
    import tun_pkg::*;

    logic       front_valid;
    logic       front_ready;
    tun_item_t  front_item;
    logic       back_valid;
    logic       back_ready;
    tun_item_t  back_item;

    tun_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_in     (tri_in),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    tun_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    tun_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .normal_out (normal_out)
    );

    // A degenerate result carries the zero vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        normal_out.valid && normal_out.degenerate |->
            normal_out.normal_x == '0 && normal_out.normal_y == '0
            && normal_out.normal_z == '0)
    else $error("degenerate result with nonzero normal");

    // Every component of a regular result stays within the unit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        normal_out.valid && !normal_out.degenerate |->
            normal_out.normal_x >= -16'sd16384 && normal_out.normal_x <= 16'sd16384
            && normal_out.normal_y >= -16'sd16384 && normal_out.normal_y <= 16'sd16384
            && normal_out.normal_z >= -16'sd16384 && normal_out.normal_z <= 16'sd16384)
    else $error("normal component out of range");

    // A regular result is never the zero vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        normal_out.valid && !normal_out.degenerate |->
            normal_out.normal_x != '0 || normal_out.normal_y != '0
            || normal_out.normal_z != '0)
    else $error("zero normal without degenerate flag");

endmodule
